>>> hw/rtl/dpd_pkg.sv
package dpd_pkg;

    // Framing characters
    localparam logic [7:0] START_CHAR = 8'h24;  // '$'
    localparam logic [7:0] END_CHAR   = 8'h23;  // '#'

    // Width of the reported length field
    localparam int unsigned LEN_W = 9;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PAYLOAD,
        PH_DIGIT1,
        PH_DIGIT2
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    // Decode one ASCII hex digit; either case accepted, value 0 when not hex
    function automatic hex_t hex_decode(logic [7:0] c);
        hex_t h;
        h.valid = 1'b0;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.valid = 1'b1;
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.valid = 1'b1;
            h.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.valid = 1'b1;
            h.value = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

>>> hw/rtl/dpd_if.sv
// Received byte channel
interface dpd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Deframed result channel
interface dpd_res_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [7:0]                 payload_byte;
    logic [dpd_pkg::LEN_W-1:0]  payload_length;
    logic [7:0]                 computed_sum;
    logic [7:0]                 received_sum;
    logic                       sum_matches;
    logic                       overflowed;

    modport source (output valid, output kind, output payload_byte,
                    output payload_length, output computed_sum,
                    output received_sum, output sum_matches,
                    output overflowed, input ready);
    modport sink   (input valid, input kind, input payload_byte,
                    input payload_length, input computed_sum,
                    input received_sum, input sum_matches,
                    input overflowed, output ready);
endinterface

>>> hw/rtl/debug_packet_deframer.sv
// Deframes $payload#HH packets from a byte stream. Bytes outside a packet,
// the break byte included, are dropped. Each payload byte comes out as one
// transaction with kind 0; the second checksum digit closes the packet with
// one kind 1 record carrying length (saturated at 511), computed and
// received sums, match flag and overflow flag. Payload beyond
// BUFFER_BYTES-1 bytes is summed but neither counted nor forwarded. The
// block takes one byte per clock: the frame state and the 8-bit running sum
// update in the cycle of acceptance and a result lands in a single output
// register. Input is held off only while that register holds a result the
// sink has not taken; when the sink takes it in the same cycle the next byte
// is accepted without a gap.
module debug_packet_deframer #(
    parameter int unsigned BUFFER_BYTES = 512
) (
    input  logic            clk,
    input  logic            rst_n,
    dpd_rx_if.sink          rx,
    dpd_res_if.source       res
);

    localparam int unsigned CNT_W = $clog2(BUFFER_BYTES);
    localparam int unsigned EXT_W = (CNT_W > dpd_pkg::LEN_W) ? CNT_W : dpd_pkg::LEN_W;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_BYTES - 1);

    // Frame state
    dpd_pkg::phase_t            phase_reg, phase_next;
    logic [7:0]                 sum_reg, sum_next;
    logic [3:0]                 digit_reg, digit_next;
    logic                       digit_ok_reg, digit_ok_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       ovf_reg, ovf_next;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    logic                       kind_reg, kind_next;
    logic [7:0]                 pbyte_reg, pbyte_next;
    logic [dpd_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [7:0]                 csum_reg, csum_next;
    logic [7:0]                 rsum_reg, rsum_next;
    logic                       match_reg, match_next;
    logic                       ovfo_reg, ovfo_next;

    logic                       accept;
    dpd_pkg::hex_t              hex;
    logic [7:0]                 rsum;
    logic [EXT_W-1:0]           count_ext;
    logic [dpd_pkg::LEN_W-1:0]  len_sat;

    assign rx.ready = !out_valid_reg || res.ready;
    assign accept   = rx.valid && rx.ready;

    assign hex       = dpd_pkg::hex_decode(rx.rx_byte);
    assign rsum      = {digit_reg, hex.value};
    assign count_ext = EXT_W'(count_reg);
    assign len_sat   = (count_ext > EXT_W'(dpd_pkg::LEN_MAX)) ? dpd_pkg::LEN_MAX
                                                              : count_ext[dpd_pkg::LEN_W-1:0];

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dpd_pkg::PH_IDLE;
            sum_reg       <= '0;
            digit_reg     <= '0;
            digit_ok_reg  <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            digit_reg     <= digit_next;
            digit_ok_reg  <= digit_ok_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        pbyte_reg <= pbyte_next;
        len_reg   <= len_next;
        csum_reg  <= csum_next;
        rsum_reg  <= rsum_next;
        match_reg <= match_next;
        ovfo_reg  <= ovfo_next;
    end

    // Next state and result
    always_comb
    begin
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        digit_next     = digit_reg;
        digit_ok_next  = digit_ok_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !res.ready;
        kind_next      = kind_reg;
        pbyte_next     = pbyte_reg;
        len_next       = len_reg;
        csum_next      = csum_reg;
        rsum_next      = rsum_reg;
        match_next     = match_reg;
        ovfo_next      = ovfo_reg;

        if (accept)
        begin
            case (phase_reg)
                dpd_pkg::PH_IDLE:
                begin
                    if (rx.rx_byte == dpd_pkg::START_CHAR)
                    begin
                        phase_next    = dpd_pkg::PH_PAYLOAD;
                        sum_next      = '0;
                        count_next    = '0;
                        ovf_next      = 1'b0;
                        digit_next    = '0;
                        digit_ok_next = 1'b0;
                    end
                end
                dpd_pkg::PH_PAYLOAD:
                begin
                    if (rx.rx_byte == dpd_pkg::END_CHAR)
                    begin
                        phase_next = dpd_pkg::PH_DIGIT1;
                    end
                    else
                    begin
                        sum_next = sum_reg + rx.rx_byte;
                        if (count_reg >= LIMIT)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            count_next     = count_reg + 1'b1;
                            out_valid_next = 1'b1;
                            kind_next      = 1'b0;
                            pbyte_next     = rx.rx_byte;
                            len_next       = '0;
                            csum_next      = '0;
                            rsum_next      = '0;
                            match_next     = 1'b0;
                            ovfo_next      = 1'b0;
                        end
                    end
                end
                dpd_pkg::PH_DIGIT1:
                begin
                    digit_ok_next = hex.valid;
                    digit_next    = hex.value;
                    phase_next    = dpd_pkg::PH_DIGIT2;
                end
                dpd_pkg::PH_DIGIT2:
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b1;
                    pbyte_next     = '0;
                    len_next       = len_sat;
                    csum_next      = sum_reg;
                    rsum_next      = rsum;
                    match_next     = hex.valid && digit_ok_reg && (rsum == sum_reg);
                    ovfo_next      = ovf_reg;
                    phase_next     = dpd_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = dpd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.kind           = kind_reg;
    assign res.payload_byte   = pbyte_reg;
    assign res.payload_length = len_reg;
    assign res.computed_sum   = csum_reg;
    assign res.received_sum   = rsum_reg;
    assign res.sum_matches    = match_reg;
    assign res.overflowed     = ovfo_reg;

`ifndef SYNTH
    // Second checksum digit always closes the packet with an end record
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == dpd_pkg::PH_DIGIT2
        |=> phase_reg == dpd_pkg::PH_IDLE && res.valid && res.kind)
        else $error("end record missing after checksum");

    // Byte count never passes the buffer limit
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LIMIT)
        else $error("byte count beyond limit");

    // Overflow only once the buffer is full
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == LIMIT)
        else $error("overflow flagged below limit");

    // Payload transactions carry zero end-record fields
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.kind |-> res.payload_length == '0 && res.computed_sum == '0
            && res.received_sum == '0 && !res.sum_matches && !res.overflowed)
        else $error("payload transaction with end fields set");
`endif

endmodule
